FILE: hdl/char_lcd_parallel_controller_unit_defines.svh
// assertion macros for the character lcd controller
// expects signals clk and rst_n in the scope of use
`ifndef CHAR_LCD_PARALLEL_CONTROLLER_UNIT_DEFINES_SVH
`define CHAR_LCD_PARALLEL_CONTROLLER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CLPC_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define CLPC_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define CLPC_ASSERT_IMP(lbl, a, c)
`define CLPC_ASSERT_NXT(lbl, a, c)
`endif
`endif

FILE: hdl/clpc_pkg.sv
// shared constants and the init byte table for the character lcd controller
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package clpc_pkg;

  localparam int TIMER_WIDTH = 16;
  localparam logic [32:0] TIMER_MAX_EXT = (33'd1 << TIMER_WIDTH) - 33'd1;

  localparam logic [1:0] CMD_TICK      = 2'd0;
  localparam logic [1:0] CMD_WR_INSTR  = 2'd1;
  localparam logic [1:0] CMD_WR_DATA   = 2'd2;
  localparam logic [1:0] CMD_BACKLIGHT = 2'd3;

  localparam logic [1:0] CFG_POWER_OFF = 2'd0;
  localparam logic [1:0] CFG_SETUP     = 2'd1;
  localparam logic [1:0] CFG_PULSE     = 2'd2;

  localparam logic [15:0] POWER_OFF_RESET = 16'd1000;
  localparam logic [7:0]  SETUP_RESET     = 8'd2;
  localparam logic [7:0]  PULSE_RESET     = 8'd12;

  localparam logic [7:0] BUS_RELEASED = 8'hFF;
  localparam logic [2:0] INIT_LAST    = 3'd4;

  function automatic logic [7:0] init_byte(input logic [2:0] step);
    logic [7:0] b;
    unique case (step)
      3'd0:    b = 8'h38;
      3'd1:    b = 8'h0C;
      3'd2:    b = 8'h01;
      3'd3:    b = 8'h06;
      default: b = 8'h02;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/char_lcd_parallel_controller_unit.sv
// a transaction's result is registered on the edge that accepts it
// throughput one transaction per cycle, set by the single result register
// a stalled result holds the input; the next transaction enters on the edge the result leaves
// reset (rst_n low, synchronous) marks the display uninitialised, idles the sequencer
// and restores the timing registers to 1000, 2 and 12 ticks
`timescale 1ns / 1ps
`default_nettype none
`include "char_lcd_parallel_controller_unit_defines.svh"
module char_lcd_parallel_controller_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [7:0]  in_value,
  input  wire logic        in_busy_line,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_bus_data,
  output logic             out_bus_drive,
  output logic             out_reg_select,
  output logic             out_read_not_write,
  output logic             out_enable_pin,
  output logic             out_backlight_pin,
  output logic             out_power_off_pin,
  output logic             out_ready_res,
  output logic             out_write_done,
  output logic             out_rejected
);

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_POWER_OFF  = 4'd1,
    PH_POWER_BUSY = 4'd2,
    PH_SETUP      = 4'd3,
    PH_PULSE      = 4'd4,
    PH_HOLD       = 4'd5,
    PH_WRITE_BUSY = 4'd6
  } phase_t;

  localparam int TW = clpc_pkg::TIMER_WIDTH;

  logic [15:0] power_off_ticks_r;
  logic [7:0]  setup_ticks_r, pulse_ticks_r;

  phase_t          phase_r, phase_nxt;
  logic [2:0]      init_step_r, init_step_nxt;
  logic            initialized_r, initialized_nxt;
  logic [7:0]      held_byte_r, held_byte_nxt;
  logic            held_is_data_r, held_is_data_nxt;
  logic [TW-1:0]   tick_count_r, tick_count_nxt;
  logic            backlight_r, backlight_nxt;

  logic            out_valid_r;
  logic [7:0]      bus_data_r, bus_data_nxt;
  logic            bus_drive_r, bus_drive_nxt;
  logic            reg_select_r, reg_select_nxt;
  logic            rnw_r, rnw_nxt;
  logic            enable_r, enable_nxt;
  logic            power_off_r, power_off_nxt;
  logic            ready_r, ready_nxt;
  logic            done_r, done_nxt;
  logic            rejected_r, rejected_nxt;

  logic            in_acc;
  logic [TW-1:0]   tick_inc;
  logic [32:0]     target_ext, target_clamped;
  logic            timer_hit;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  // shared saturating timer, target picked by phase
  always_comb begin
    unique case (phase_r)
      PH_POWER_OFF: target_ext = {17'd0, power_off_ticks_r};
      PH_PULSE:     target_ext = {25'd0, pulse_ticks_r};
      default:      target_ext = {25'd0, setup_ticks_r};
    endcase
    target_clamped = (target_ext > clpc_pkg::TIMER_MAX_EXT) ? clpc_pkg::TIMER_MAX_EXT
                                                            : target_ext;
    tick_inc  = (tick_count_r != {TW{1'b1}}) ? tick_count_r + {{(TW-1){1'b0}}, 1'b1}
                                             : tick_count_r;
    timer_hit = (33'(tick_inc) >= target_clamped);
  end

  always_comb begin
    phase_nxt        = phase_r;
    init_step_nxt    = init_step_r;
    initialized_nxt  = initialized_r;
    held_byte_nxt    = held_byte_r;
    held_is_data_nxt = held_is_data_r;
    tick_count_nxt   = tick_count_r;
    backlight_nxt    = backlight_r;
    done_nxt         = 1'b0;
    rejected_nxt     = 1'b0;

    unique case (in_cmd)
      clpc_pkg::CMD_BACKLIGHT: backlight_nxt = in_value[0];
      clpc_pkg::CMD_WR_INSTR, clpc_pkg::CMD_WR_DATA: begin
        if (phase_r != PH_IDLE) begin
          rejected_nxt = 1'b1;
        end else begin
          held_byte_nxt    = in_value;
          held_is_data_nxt = (in_cmd == clpc_pkg::CMD_WR_DATA);
          phase_nxt        = initialized_r ? PH_SETUP : PH_POWER_OFF;
          tick_count_nxt   = '0;
        end
      end
      default: begin
        unique case (phase_r)
          PH_IDLE: ;
          PH_POWER_OFF: begin
            tick_count_nxt = tick_inc;
            if (timer_hit) begin
              phase_nxt      = PH_POWER_BUSY;
              tick_count_nxt = '0;
            end
          end
          PH_POWER_BUSY: begin
            if (!in_busy_line) begin
              init_step_nxt  = '0;
              phase_nxt      = PH_SETUP;
              tick_count_nxt = '0;
            end
          end
          PH_SETUP: begin
            tick_count_nxt = tick_inc;
            if (timer_hit) begin
              phase_nxt      = PH_PULSE;
              tick_count_nxt = '0;
            end
          end
          PH_PULSE: begin
            tick_count_nxt = tick_inc;
            if (timer_hit) begin
              phase_nxt      = PH_HOLD;
              tick_count_nxt = '0;
            end
          end
          PH_HOLD: phase_nxt = PH_WRITE_BUSY;
          PH_WRITE_BUSY: begin
            if (!in_busy_line) begin
              tick_count_nxt = '0;
              if (!initialized_r) begin
                // walk the init bytes, then send the held byte
                if (init_step_r < clpc_pkg::INIT_LAST) begin
                  init_step_nxt = init_step_r + 3'd1;
                end else begin
                  initialized_nxt = 1'b1;
                  init_step_nxt   = '0;
                end
                phase_nxt = PH_SETUP;
              end else begin
                done_nxt  = 1'b1;
                phase_nxt = PH_IDLE;
              end
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    endcase
  end

  // pin levels after this transaction
  always_comb begin
    bus_data_nxt   = clpc_pkg::BUS_RELEASED;
    bus_drive_nxt  = 1'b0;
    reg_select_nxt = 1'b0;
    rnw_nxt        = 1'b1;
    enable_nxt     = 1'b0;
    unique case (phase_nxt)
      PH_POWER_BUSY, PH_WRITE_BUSY: enable_nxt = 1'b1;
      PH_SETUP, PH_PULSE, PH_HOLD: begin
        bus_data_nxt   = initialized_nxt ? held_byte_nxt
                                         : clpc_pkg::init_byte(init_step_nxt);
        bus_drive_nxt  = 1'b1;
        reg_select_nxt = initialized_nxt && held_is_data_nxt;
        rnw_nxt        = 1'b0;
        enable_nxt     = (phase_nxt == PH_PULSE);
      end
      default: ;
    endcase
    power_off_nxt = !initialized_nxt &&
                    ((phase_nxt == PH_IDLE) || (phase_nxt == PH_POWER_OFF));
    ready_nxt     = (phase_nxt == PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_off_ticks_r <= clpc_pkg::POWER_OFF_RESET;
      setup_ticks_r     <= clpc_pkg::SETUP_RESET;
      pulse_ticks_r     <= clpc_pkg::PULSE_RESET;
      phase_r           <= PH_IDLE;
      init_step_r       <= '0;
      initialized_r     <= 1'b0;
      held_byte_r       <= '0;
      held_is_data_r    <= 1'b0;
      tick_count_r      <= '0;
      backlight_r       <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          clpc_pkg::CFG_POWER_OFF: power_off_ticks_r <= cfg_wdata;
          clpc_pkg::CFG_SETUP:     setup_ticks_r     <= cfg_wdata[7:0];
          clpc_pkg::CFG_PULSE:     pulse_ticks_r     <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        phase_r        <= phase_nxt;
        init_step_r    <= init_step_nxt;
        initialized_r  <= initialized_nxt;
        held_byte_r    <= held_byte_nxt;
        held_is_data_r <= held_is_data_nxt;
        tick_count_r   <= tick_count_nxt;
        backlight_r    <= backlight_nxt;
        out_valid_r    <= 1'b1;
        // result payload, loaded with each accepted transaction
        bus_data_r     <= bus_data_nxt;
        bus_drive_r    <= bus_drive_nxt;
        reg_select_r   <= reg_select_nxt;
        rnw_r          <= rnw_nxt;
        enable_r       <= enable_nxt;
        power_off_r    <= power_off_nxt;
        ready_r        <= ready_nxt;
        done_r         <= done_nxt;
        rejected_r     <= rejected_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_bus_data       = bus_data_r;
  assign out_bus_drive      = bus_drive_r;
  assign out_reg_select     = reg_select_r;
  assign out_read_not_write = rnw_r;
  assign out_enable_pin     = enable_r;
  assign out_backlight_pin  = backlight_r;
  assign out_power_off_pin  = power_off_r;
  assign out_ready_res      = ready_r;
  assign out_write_done     = done_r;
  assign out_rejected       = rejected_r;

  `CLPC_ASSERT_NXT(a_reject_busy, in_acc && ((in_cmd == clpc_pkg::CMD_WR_INSTR) || (in_cmd == clpc_pkg::CMD_WR_DATA)) && (phase_r != PH_IDLE), out_rejected)
  `CLPC_ASSERT_IMP(a_done_idle, out_valid_r && done_r, ready_r)
  `CLPC_ASSERT_IMP(a_drive_write, out_valid_r, bus_drive_r != rnw_r)
  `CLPC_ASSERT_IMP(a_unpowered_no_strobe, out_valid_r && power_off_r, !enable_r && !bus_drive_r)
  `CLPC_ASSERT_NXT(a_accept_result, in_acc, out_valid_r)

endmodule
`default_nettype wire

FILE: tb/tb.sv
// self-checking testbench for char_lcd_parallel_controller_unit: queue-fed driver,
// clocked monitor with a cycle-free pin predictor, random idles and a long output stall
// depends on clpc_pkg and the unit's rtl
`timescale 1ns / 1ps
module tb;

  localparam logic [1:0]  CFG_UNUSED = 2'd3;
  localparam int unsigned TICK_MAX   = 32'(clpc_pkg::TIMER_MAX_EXT);
  localparam logic [39:0] INIT_SEQ   = {8'h38, 8'h0C, 8'h01, 8'h06, 8'h02};
  localparam int          HOLD_CYCLES = 400;

  typedef enum logic [2:0] {
    ST_IDLE, ST_POWER_OFF, ST_POWER_BUSY, ST_SETUP, ST_PULSE, ST_HOLD, ST_WRITE_BUSY
  } seq_state_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] value;
    logic       busy;
  } lcd_item_t;

  typedef struct packed {
    logic [7:0] bus_data;
    logic       bus_drive;
    logic       reg_select;
    logic       read_not_write;
    logic       enable_pin;
    logic       backlight_pin;
    logic       power_off_pin;
    logic       ready_res;
    logic       write_done;
    logic       rejected;
  } lcd_pins_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = clpc_pkg::CFG_POWER_OFF;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = clpc_pkg::CMD_TICK;
  logic [7:0]  in_value = '0;
  logic        in_busy_line = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_bus_data;
  logic        out_bus_drive;
  logic        out_reg_select;
  logic        out_read_not_write;
  logic        out_enable_pin;
  logic        out_backlight_pin;
  logic        out_power_off_pin;
  logic        out_ready_res;
  logic        out_write_done;
  logic        out_rejected;

  char_lcd_parallel_controller_unit u_top (.*);

  always #5 clk = ~clk;

  lcd_pins_t obs_pins;
  assign obs_pins = {out_bus_data, out_bus_drive, out_reg_select, out_read_not_write,
                     out_enable_pin, out_backlight_pin, out_power_off_pin, out_ready_res,
                     out_write_done, out_rejected};

  lcd_item_t pend_q[$];
  lcd_pins_t pins_q[$];
  logic      in_taken = 1'b0;
  int        send_idle_pct = 25;
  int        recv_idle_pct = 25;
  logic      hold_req = 1'b0;
  logic      hold_off = 1'b0;
  int        err_cnt = 0;

  // predictor state and its copy of the timing registers
  seq_state_t  seq_st = ST_IDLE;
  logic [2:0]  init_step = '0;
  logic        lcd_ready = 1'b0;
  logic [7:0]  held_byte = '0;
  logic        held_is_data = 1'b0;
  int unsigned tick_cnt = 0;
  logic        bl_level = 1'b0;
  int unsigned po_ticks = 32'(clpc_pkg::POWER_OFF_RESET);
  int unsigned su_ticks = 32'(clpc_pkg::SETUP_RESET);
  int unsigned pe_ticks = 32'(clpc_pkg::PULSE_RESET);

  function automatic logic timer_hit(input int unsigned target);
    int unsigned lim;
    lim = (target > TICK_MAX) ? TICK_MAX : target;
    if (tick_cnt < TICK_MAX) tick_cnt++;
    return tick_cnt >= lim;
  endfunction

  function automatic lcd_pins_t lcd_predict(input logic [1:0] cmd, input logic [7:0] val,
                                            input logic busy);
    lcd_pins_t p;
    logic fin;
    logic rej;
    fin = 1'b0;
    rej = 1'b0;
    if (cmd == clpc_pkg::CMD_BACKLIGHT) begin
      bl_level = val[0];
    end else if (cmd == clpc_pkg::CMD_WR_INSTR || cmd == clpc_pkg::CMD_WR_DATA) begin
      if (seq_st != ST_IDLE) begin
        rej = 1'b1;
      end else begin
        held_byte = val;
        held_is_data = (cmd == clpc_pkg::CMD_WR_DATA);
        tick_cnt = 0;
        seq_st = lcd_ready ? ST_SETUP : ST_POWER_OFF;
      end
    end else begin
      unique case (seq_st)
        ST_POWER_OFF: if (timer_hit(po_ticks)) begin
          seq_st = ST_POWER_BUSY;
          tick_cnt = 0;
        end
        ST_POWER_BUSY: if (!busy) begin
          init_step = '0;
          seq_st = ST_SETUP;
          tick_cnt = 0;
        end
        ST_SETUP: if (timer_hit(su_ticks)) begin
          seq_st = ST_PULSE;
          tick_cnt = 0;
        end
        ST_PULSE: if (timer_hit(pe_ticks)) begin
          seq_st = ST_HOLD;
          tick_cnt = 0;
        end
        ST_HOLD: seq_st = ST_WRITE_BUSY;
        ST_WRITE_BUSY: if (!busy) begin
          if (!lcd_ready) begin
            // walk the init table, then send the byte that started it all
            if (init_step < clpc_pkg::INIT_LAST) begin
              init_step++;
            end else begin
              lcd_ready = 1'b1;
              init_step = '0;
            end
            seq_st = ST_SETUP;
          end else begin
            fin = 1'b1;
            seq_st = ST_IDLE;
          end
          tick_cnt = 0;
        end
        default: ;
      endcase
    end

    p.bus_data = clpc_pkg::BUS_RELEASED;
    p.bus_drive = 1'b0;
    p.reg_select = 1'b0;
    p.read_not_write = 1'b1;
    p.enable_pin = 1'b0;
    unique case (seq_st)
      ST_POWER_BUSY, ST_WRITE_BUSY: p.enable_pin = 1'b1;
      ST_SETUP, ST_PULSE, ST_HOLD: begin
        p.bus_data = lcd_ready ? held_byte
                               : INIT_SEQ[8 * (clpc_pkg::INIT_LAST - init_step) +: 8];
        p.bus_drive = 1'b1;
        p.reg_select = lcd_ready && held_is_data;
        p.read_not_write = 1'b0;
        p.enable_pin = (seq_st == ST_PULSE);
      end
      default: ;
    endcase
    p.backlight_pin = bl_level;
    p.power_off_pin = !lcd_ready && (seq_st == ST_IDLE || seq_st == ST_POWER_OFF);
    p.ready_res = (seq_st == ST_IDLE);
    p.write_done = fin;
    p.rejected = rej;
    return p;
  endfunction

  function automatic string pins_str(input lcd_pins_t p);
    return $sformatf("data=%h drv=%b rs=%b rw=%b e=%b bl=%b pwroff=%b rdy=%b done=%b rej=%b",
                     p.bus_data, p.bus_drive, p.reg_select, p.read_not_write, p.enable_pin,
                     p.backlight_pin, p.power_off_pin, p.ready_res, p.write_done, p.rejected);
  endfunction

  function automatic void flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%t: %s", $realtime, msg);
  endfunction

  // driver: present the next pending transaction once the current one is taken
  always @(negedge clk) begin : drive_in
    lcd_item_t cur;
    if (rst_n && (!in_valid || in_taken)) begin
      if (pend_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cur = pend_q.pop_front();
        in_valid <= 1'b1;
        in_cmd <= cur.cmd;
        in_value <= cur.value;
        in_busy_line <= cur.busy;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) out_stall <= hold_off || ($urandom_range(0, 99) < recv_idle_pct);
  end

  // long output stall so the unit backs up and stalls its input
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // monitor: check results against the oldest prediction, predict on each accepted input
  always @(posedge clk) begin : watch
    lcd_pins_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (pins_q.size() == 0) begin
          flag_error({"result with no transaction pending: ", pins_str(obs_pins)});
        end else begin
          want = pins_q.pop_front();
          if (obs_pins !== want)
            flag_error({"pin mismatch\n  exp ", pins_str(want), "\n  got ",
                        pins_str(obs_pins)});
        end
      end
      if (in_valid && !in_stall) pins_q.push_back(lcd_predict(in_cmd, in_value, in_busy_line));
    end
  end

  task automatic push_item(input logic [1:0] c, input logic [7:0] v, input logic b);
    pend_q.push_back('{c, v, b});
  endtask

  task automatic drain();
    while (pend_q.size() != 0 || in_valid || pins_q.size() != 0) @(negedge clk);
  endtask

  // keep ticking until the predicted sequencer is back to idle
  task automatic run_to_idle(input int busy_pct);
    drain();
    while (seq_st != ST_IDLE) begin
      repeat (16) push_item(clpc_pkg::CMD_TICK, 8'($urandom),
                            $urandom_range(0, 99) < busy_pct);
      drain();
    end
  endtask

  task automatic set_timing(input logic [15:0] po, input logic [7:0] su,
                            input logic [7:0] pe, input bit poke_unused);
    cfg_we <= 1'b1;
    cfg_index <= clpc_pkg::CFG_POWER_OFF;
    cfg_wdata <= po;
    @(negedge clk);
    cfg_index <= clpc_pkg::CFG_SETUP;
    cfg_wdata <= {8'($urandom), su};
    @(negedge clk);
    cfg_index <= clpc_pkg::CFG_PULSE;
    cfg_wdata <= {8'($urandom), pe};
    @(negedge clk);
    if (poke_unused) begin
      cfg_index <= CFG_UNUSED;
      cfg_wdata <= 16'hFFFF;
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    po_ticks = 32'(po);
    su_ticks = 32'(su);
    pe_ticks = 32'(pe);
  endtask

  // mostly a write followed by a run of ticks, sometimes a stray transaction
  task automatic random_traffic(input int count, input int busy_pct);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 4) != 0) begin
        push_item(2'($urandom_range(clpc_pkg::CMD_WR_INSTR, clpc_pkg::CMD_WR_DATA)),
                  8'($urandom), 1'($urandom));
        len = $urandom_range(4, 40);
        repeat (len) begin
          if ($urandom_range(0, 19) == 0)
            push_item(clpc_pkg::CMD_BACKLIGHT, 8'($urandom), 1'($urandom));
          else
            push_item(clpc_pkg::CMD_TICK, 8'($urandom), $urandom_range(0, 99) < busy_pct);
        end
        sent += len + 1;
      end else begin
        push_item(2'($urandom), 8'($urandom), 1'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // short power-off wait, setup and pulse stay at their reset values
    cfg_we <= 1'b1;
    cfg_index <= clpc_pkg::CFG_POWER_OFF;
    cfg_wdata <= 16'd24;
    @(negedge clk);
    cfg_we <= 1'b0;
    po_ticks = 24;

    // idle ticks, backlight bit 0, first write starts init
    push_item(clpc_pkg::CMD_TICK, 8'h00, 1'b0);
    push_item(clpc_pkg::CMD_TICK, 8'hFF, 1'b1);
    push_item(clpc_pkg::CMD_BACKLIGHT, 8'hFF, 1'b0);
    push_item(clpc_pkg::CMD_BACKLIGHT, 8'hFE, 1'b1);
    push_item(clpc_pkg::CMD_BACKLIGHT, 8'h01, 1'b0);
    push_item(clpc_pkg::CMD_WR_DATA, 8'hA5, 1'b0);
    push_item(clpc_pkg::CMD_WR_INSTR, 8'h5A, 1'b1);
    push_item(clpc_pkg::CMD_TICK, 8'h00, 1'b1);
    push_item(clpc_pkg::CMD_WR_DATA, 8'hFF, 1'b0);
    push_item(clpc_pkg::CMD_BACKLIGHT, 8'h00, 1'b0);
    run_to_idle(40);

    // zero timing ends each phase on its first tick
    set_timing(16'd0, 8'd0, 8'd0, 1'b1);
    push_item(clpc_pkg::CMD_WR_INSTR, 8'h00, 1'b0);
    push_item(clpc_pkg::CMD_WR_INSTR, 8'hFF, 1'b0);
    run_to_idle(30);

    set_timing(16'hFFFF, 8'd1, 8'd1, 1'b0);
    push_item(clpc_pkg::CMD_WR_DATA, 8'hFF, 1'b1);
    push_item(clpc_pkg::CMD_BACKLIGHT, 8'h01, 1'b0);
    run_to_idle(30);

    set_timing(16'd1, 8'd255, 8'd40, 1'b0);
    push_item(clpc_pkg::CMD_WR_INSTR, 8'h80, 1'b0);
    push_item(clpc_pkg::CMD_TICK, 8'h00, 1'b0);
    push_item(clpc_pkg::CMD_WR_DATA, 8'h7F, 1'b0);
    run_to_idle(20);

    set_timing(clpc_pkg::POWER_OFF_RESET, clpc_pkg::SETUP_RESET, clpc_pkg::PULSE_RESET, 1'b0);
    random_traffic(180, 30);
    run_to_idle(0);

    // stretch with no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_timing(16'($urandom), 8'($urandom_range(0, 6)), 8'($urandom_range(0, 10)), 1'b0);
    random_traffic(180, 30);
    run_to_idle(0);
    send_idle_pct = 25;
    recv_idle_pct = 25;

    set_timing(16'($urandom), 8'($urandom_range(0, 6)), 8'($urandom_range(0, 10)), 1'b0);
    hold_req = 1'b1;
    random_traffic(180, 40);
    run_to_idle(0);

    set_timing(16'($urandom), 8'($urandom_range(0, 6)), 8'($urandom_range(0, 10)), 1'b0);
    random_traffic(180, 20);

    drain();
    repeat (8) @(negedge clk);
    if (err_cnt == 0)
      $display("[char_lcd_parallel_controller_unit] OK");
    else
      $display("[char_lcd_parallel_controller_unit] ERROR");
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("[char_lcd_parallel_controller_unit] ERROR");
    $finish;
  end

endmodule
